FILE: rtl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ucd_pkg;

  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned VALUE_BITS = 21;
  localparam int unsigned WIDTH_BITS = 3;
  localparam int unsigned POINT_INDEX_BITS = 16;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

  localparam logic [VALUE_BITS-1:0] ANIMAL_A_LO = 21'h1F400;
  localparam logic [VALUE_BITS-1:0] ANIMAL_A_HI = 21'h1F43F;
  localparam logic [VALUE_BITS-1:0] ANIMAL_B_LO = 21'h1F980;
  localparam logic [VALUE_BITS-1:0] ANIMAL_B_HI = 21'h1F99E;

  localparam logic [WIDTH_BITS-1:0] WIDTH_NONE = 3'd0;
  localparam logic [WIDTH_BITS-1:0] WIDTH_ONE = 3'd1;
  localparam logic [WIDTH_BITS-1:0] WIDTH_TWO = 3'd2;
  localparam logic [WIDTH_BITS-1:0] WIDTH_THREE = 3'd3;
  localparam logic [WIDTH_BITS-1:0] WIDTH_FOUR = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STRAY     = 2'd1,
    ST_BAD_START = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0] partial_value;
    logic [1:0]            bytes_remaining;
    logic [WIDTH_BITS-1:0] current_width;
    logic [INDEX_BITS-1:0] point_counter;
  } dec_state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]       code_value;
    logic [WIDTH_BITS-1:0]       byte_width;
    logic [POINT_INDEX_BITS-1:0] point_index;
    logic                        animal_flag;
    status_e                     status;
    logic                        final_result;
  } dec_result_t;

endpackage

`default_nettype wire

FILE: rtl/ucd_step.sv
// ----------------------------------------------------------------------------
// ucd_step
// Next-state and result logic for one byte of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module ucd_step (
  input  ucd_pkg::dec_state_t  state_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 end_of_text_i,
  output ucd_pkg::dec_state_t  state_o,
  output logic                 res_valid_o,
  output ucd_pkg::dec_result_t res_o
);
  import ucd_pkg::*;

  logic [VALUE_BITS-1:0] shifted;
  logic [1:0]            rem_dec;
  logic [31:0]           index_ext;
  logic                  advance;
  logic [WIDTH_BITS-1:0] start_width;
  logic [VALUE_BITS-1:0] start_value;

  assign shifted   = {state_i.partial_value[VALUE_BITS-7:0], in_byte_i[5:0]};
  assign rem_dec   = state_i.bytes_remaining - 2'd1;
  assign index_ext = 32'(state_i.point_counter);

  always_comb begin
    priority if (!in_byte_i[5]) begin
      start_width = WIDTH_TWO;
      start_value = VALUE_BITS'(in_byte_i[4:0]);
    end else if (!in_byte_i[4]) begin
      start_width = WIDTH_THREE;
      start_value = VALUE_BITS'(in_byte_i[3:0]);
    end else begin
      start_width = WIDTH_FOUR;
      start_value = VALUE_BITS'(in_byte_i[2:0]);
    end
  end

  always_comb begin
    state_o                  = state_i;
    res_valid_o              = 1'b0;
    res_o                    = '0;
    res_o.point_index        = index_ext[POINT_INDEX_BITS-1:0];
    res_o.final_result       = end_of_text_i;
    res_o.status             = ST_OK;
    advance                  = 1'b0;

    priority if (state_i.bytes_remaining != 2'd0) begin
      state_o.partial_value   = shifted;
      state_o.bytes_remaining = rem_dec;
      if (rem_dec == 2'd0) begin
        res_valid_o             = 1'b1;
        res_o.code_value        = shifted;
        res_o.byte_width        = state_i.current_width;
        advance                 = 1'b1;
        state_o.partial_value   = '0;
        state_o.current_width   = WIDTH_NONE;
      end else if (end_of_text_i) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_TRUNC;
      end
    end else if (!in_byte_i[7]) begin
      res_valid_o      = 1'b1;
      res_o.code_value = VALUE_BITS'(in_byte_i);
      res_o.byte_width = WIDTH_ONE;
      advance          = 1'b1;
    end else if (in_byte_i[7:6] == 2'b10) begin
      res_valid_o  = 1'b1;
      res_o.status = ST_STRAY;
    end else if (in_byte_i[7:3] == 5'b11111) begin
      res_valid_o  = 1'b1;
      res_o.status = ST_BAD_START;
    end else begin
      state_o.partial_value   = start_value;
      state_o.current_width   = start_width;
      state_o.bytes_remaining = 2'(start_width - WIDTH_ONE);
      if (end_of_text_i) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_TRUNC;
      end
    end

    res_o.animal_flag =
      ((res_o.code_value >= ANIMAL_A_LO) && (res_o.code_value <= ANIMAL_A_HI)) ||
      ((res_o.code_value >= ANIMAL_B_LO) && (res_o.code_value <= ANIMAL_B_HI));

    if (advance && (state_i.point_counter != INDEX_MAX)) begin
      state_o.point_counter = state_i.point_counter + INDEX_BITS'(1);
    end

    if (end_of_text_i) begin
      state_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf8_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Decodes a UTF-8 byte stream into code points, one byte beat per cycle while no held result is stalled.
// Each result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle unless a held result is stalled; the limit is
// the single decode step between the state registers and the output register.
// Reset: decoder state and output valid clear; the next byte starts index 0.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_value_o,
  output logic [2:0]  byte_width_o,
  output logic [15:0] point_index_o,
  output logic        animal_flag_o,
  output logic [1:0]  status_o,
  output logic        final_result_o
);
  import ucd_pkg::*;

  dec_state_t  state_q, state_d;
  dec_result_t res_q, res_d;
  logic        res_valid;
  logic        out_valid_q;
  logic        accept;

  ucd_step u_step (
    .state_i       (state_q),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res_d)
  );

  // stall only when a held result cannot leave this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_value_o   = res_q.code_value;
  assign byte_width_o   = res_q.byte_width;
  assign point_index_o  = res_q.point_index;
  assign animal_flag_o  = res_q.animal_flag;
  assign status_o       = res_q.status;
  assign final_result_o = res_q.final_result;

endmodule

`default_nettype wire

FILE: tb/utf8_codepoint_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_tb
// Self-checking bench for the UTF-8 decoder. Byte beats go in through a
// valid/stall sender. An in-bench model predicts each code point or error
// result, and a scoreboard compares every output beat in order. Traffic is a
// directed set, then random strings under three idling mixes with one long
// receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder_tb;
  import ucd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;

  class codepoint_board;
    dec_result_t pending_points[$];
    logic [VALUE_BITS-1:0] partial;
    logic [1:0] remaining;
    logic [WIDTH_BITS-1:0] cur_width;
    logic [INDEX_BITS-1:0] counter;
    int failures;
    int points_ok;
    int errors_seen;

    function new();
      clear();
    endfunction

    function void clear();
      partial = '0;
      remaining = '0;
      cur_width = WIDTH_NONE;
      counter = '0;
    endfunction

    function void bump_index();
      if (counter < INDEX_MAX) counter++;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      dec_result_t r;
      bit emit;
      r = '0;
      emit = 1'b0;
      r.point_index = counter[POINT_INDEX_BITS-1:0];
      r.status = ST_OK;
      if (remaining != 0) begin
        partial = {partial[VALUE_BITS-7:0], b[5:0]};
        remaining--;
        if (remaining == 0) begin
          r.code_value = partial;
          r.byte_width = cur_width;
          r.final_result = last;
          emit = 1'b1;
          bump_index();
          partial = '0;
          cur_width = WIDTH_NONE;
        end else if (last) begin
          r.status = ST_TRUNC;
          r.final_result = 1'b1;
          emit = 1'b1;
        end
      end else if (!b[7]) begin
        r.code_value = {{(VALUE_BITS-8){1'b0}}, b};
        r.byte_width = WIDTH_ONE;
        r.final_result = last;
        emit = 1'b1;
        bump_index();
      end else if (b[7:6] == 2'b10) begin
        r.status = ST_STRAY;
        r.final_result = last;
        emit = 1'b1;
      end else if (b[7:3] == 5'b11111) begin
        r.status = ST_BAD_START;
        r.final_result = last;
        emit = 1'b1;
      end else begin
        if (b[7:5] == 3'b110) begin
          partial = {{(VALUE_BITS-5){1'b0}}, b[4:0]};
          cur_width = WIDTH_TWO;
        end else if (b[7:4] == 4'b1110) begin
          partial = {{(VALUE_BITS-4){1'b0}}, b[3:0]};
          cur_width = WIDTH_THREE;
        end else begin
          partial = {{(VALUE_BITS-3){1'b0}}, b[2:0]};
          cur_width = WIDTH_FOUR;
        end
        remaining = 2'(cur_width - 1);
        if (last) begin
          r.status = ST_TRUNC;
          r.final_result = 1'b1;
          emit = 1'b1;
        end
      end
      r.animal_flag = (r.code_value >= ANIMAL_A_LO && r.code_value <= ANIMAL_A_HI) ||
                      (r.code_value >= ANIMAL_B_LO && r.code_value <= ANIMAL_B_HI);
      if (emit) pending_points.push_back(r);
      if (last) clear();
    endfunction

    function void check_point(logic [20:0] code, logic [2:0] bw, logic [15:0] idx,
                              logic animal, logic [1:0] st, logic fin);
      dec_result_t exp;
      if (pending_points.size() == 0) begin
        $error("unexpected result beat: code_value %0h status %0d", code, st);
        failures++;
        return;
      end
      exp = pending_points.pop_front();
      if (exp.status == ST_OK) points_ok++;
      else errors_seen++;
      if (code !== exp.code_value) begin
        $error("code_value: expected %0h, got %0h", exp.code_value, code);
        failures++;
      end
      if (bw !== exp.byte_width) begin
        $error("byte_width: expected %0d, got %0d", exp.byte_width, bw);
        failures++;
      end
      if (idx !== exp.point_index) begin
        $error("point_index: expected %0d, got %0d", exp.point_index, idx);
        failures++;
      end
      if (animal !== exp.animal_flag) begin
        $error("animal_flag: expected %0b, got %0b", exp.animal_flag, animal);
        failures++;
      end
      if (st !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, st);
        failures++;
      end
      if (fin !== exp.final_result) begin
        $error("final_result: expected %0b, got %0b", exp.final_result, fin);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [20:0] code_value_o;
  logic [2:0]  byte_width_o;
  logic [15:0] point_index_o;
  logic        animal_flag_o;
  logic [1:0]  status_o;
  logic        final_result_o;

  codepoint_board board = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int cycle_count = 0;
  bit hold_go = 1'b0;
  logic hold_on = 1'b0;

  utf8_codepoint_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_value_o   (code_value_o),
    .byte_width_o   (byte_width_o),
    .point_index_o  (point_index_o),
    .animal_flag_o  (animal_flag_o),
    .status_o       (status_o),
    .final_result_o (final_result_o)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < rx_idle_pct);
  end

  // long receiver hold-off so the decoder backs up into its input
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_point(code_value_o, byte_width_o, point_index_o, animal_flag_o,
                        status_o, final_result_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_text_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_byte(b, last);
    bytes_sent++;
    if (last) strings_sent++;
    @(negedge clk_i);
  endtask

  // encode value v in w bytes, send only the first n_send of them
  task automatic send_point(logic [20:0] v, int w, int n_send, bit last);
    logic [7:0] seq [4];
    logic [1:0] tag;
    case (w)
      1: seq[0] = {1'b0, v[6:0]};
      2: seq[0] = {3'b110, v[10:6]};
      3: seq[0] = {4'b1110, v[15:12]};
      default: seq[0] = {5'b11110, v[20:18]};
    endcase
    for (int k = 1; k < w; k++) begin
      tag = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b10;
      seq[k] = {tag, v[6*(w-1-k) +: 6]};
    end
    for (int k = 0; k < n_send; k++) send_byte(seq[k], last && (k == n_send - 1));
  endtask

  task automatic send_string();
    int n_pts;
    int kind;
    int w;
    logic [20:0] v;
    bit last_pt;
    n_pts = $urandom_range(1, 10);
    for (int i = 0; i < n_pts; i++) begin
      last_pt = (i == n_pts - 1);
      kind = $urandom_range(0, 99);
      w = $urandom_range(1, 4);
      case (w)
        1: v = 21'($urandom_range(0, 127));
        2: v = 21'($urandom_range(0, 2047));
        3: v = 21'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(0, 3))
            0: v = 21'($urandom_range(int'(ANIMAL_A_LO) - 2, int'(ANIMAL_A_HI) + 2));
            1: v = 21'($urandom_range(int'(ANIMAL_B_LO) - 2, int'(ANIMAL_B_HI) + 2));
            default: v = 21'($urandom);
          endcase
        end
      endcase
      if (kind < 84) send_point(v, w, w, last_pt);
      else if (kind < 89) send_byte({2'b10, 6'($urandom)}, last_pt);
      else if (kind < 93) send_byte({5'b11111, 3'($urandom)}, last_pt);
      else if (kind < 97) send_point(v, 4, $urandom_range(1, 3), last_pt);
      else send_byte(8'($urandom), last_pt);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 8;
    rx_idle_pct = 66;
    send_point(21'h0, 1, 1, 1'b0);
    send_point(21'h7F, 1, 1, 1'b0);
    send_point(21'h0, 2, 2, 1'b0);
    send_point(21'hA9, 2, 2, 1'b0);
    send_point(21'hFFFF, 3, 3, 1'b0);
    send_point(ANIMAL_A_LO, 4, 4, 1'b0);
    send_point(ANIMAL_B_HI, 4, 4, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_point(21'h20AC, 3, 2, 1'b1);
    send_point(21'h100000, 4, 1, 1'b1);
    send_point(21'h1FFFFF, 4, 4, 1'b1);

    while (bytes_sent < 600) send_string();
    tx_idle_pct = 66;
    rx_idle_pct = 8;
    while (bytes_sent < 1175) send_string();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    while (bytes_sent < 1750) send_string();
    in_valid_i <= 1'b0;

    while (board.pending_points.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings under three idling mixes plus a hold-off;",
             bytes_sent, strings_sent);
    $display("%0d code points and %0d error results checked.",
             board.points_ok, board.errors_seen);
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: utf8_codepoint_decoder.f
rtl/ucd_pkg.sv
rtl/ucd_step.sv
rtl/utf8_codepoint_decoder.sv
tb/utf8_codepoint_decoder_tb.sv
